[sv/lget_pkg.sv]
// -----------------------------------------------------------------------------
// LED graph edge table package
// Shared sizes, request and result types for the edge table block.
// -----------------------------------------------------------------------------
package lget_pkg;

  // Table and id sizes.
  localparam int unsigned MaxEdges = 64;
  localparam int unsigned NodeBits = 8;
  localparam int unsigned LedBits  = 16;
  localparam int unsigned NthBits  = 7;

  // Derived widths: edge index, edge count (holds MaxEdges itself), rank counter.
  localparam int unsigned IdxBits  = $clog2(MaxEdges);
  localparam int unsigned CntBits  = $clog2(MaxEdges + 1);
  localparam int unsigned IncBits  = $clog2(2 * MaxEdges + 1);
  localparam int unsigned SeenBits = (NthBits + 1 > IncBits) ? NthBits + 1 : IncBits;

  // One memory word holds the front and back node of an edge.
  localparam int unsigned EntryBits = 2 * NodeBits;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_COUNT  = 2'd2,
    KIND_FIND   = 2'd3
  } kind_e;

  // Input request.
  typedef struct packed {
    kind_e                kind;
    logic [NodeBits-1:0]  front_node;
    logic [NodeBits-1:0]  back_node;
    logic [LedBits-1:0]   end_led;
    logic [NodeBits-1:0]  query_node;
    logic [NthBits-1:0]   nth;
    logic                 ignore_enable;
    logic [IdxBits-1:0]   ignore_edge;
  } in_t;

  // Output result.
  typedef struct packed {
    logic                 found;
    logic [IdxBits-1:0]   edge_index;
    logic                 reversed;
    logic [CntBits-1:0]   connection_count;
    logic [NodeBits:0]    node_count;
    logic [LedBits:0]     total_leds;
    logic                 table_full;
  } out_t;

  // Per-request outcome held until the output register is free.
  typedef struct packed {
    logic                 found;
    logic [IdxBits-1:0]   idx;
    logic                 rev;
    logic [CntBits-1:0]   conn;
    logic                 full;
  } res_t;

endpackage

[sv/lget_ram.sv]
// -----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// -----------------------------------------------------------------------------
module lget_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/led_graph_edge_table.sv]
// -----------------------------------------------------------------------------
// LED graph edge table
// Edge table with append, clear, incidence count and n-th incidence search.
// -----------------------------------------------------------------------------
// The block takes one request at a time and gives one result per request.
// Clear and append go from acceptance straight to the done state, which is left
// once the output register is free. Count and find read the edge memory one
// entry per cycle through its single read port, scanning the table's entries in
// order; a find that hits early stops the scan there. A finished result
// sits in the output register, and a new request is taken while it waits.
module led_graph_edge_table
  import lget_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state_q, state_d;
  in_t                 req_q, req_d;
  res_t                res_q, res_d;
  out_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic [CntBits-1:0]  total_q, total_d;
  logic [NodeBits-1:0] max_node_q, max_node_d;
  logic [LedBits-1:0]  max_led_q, max_led_d;
  logic [CntBits-1:0]  issue_q, issue_d;
  logic                pend_q, pend_d;
  logic [IdxBits-1:0]  pend_idx_q, pend_idx_d;
  logic [SeenBits-1:0] seen_q, seen_d;
  logic [CntBits-1:0]  conn_q, conn_d;

  logic                accept;
  logic                out_free;
  logic                ram_we;
  logic [EntryBits-1:0] ram_rdata;
  logic [NodeBits-1:0] rd_front, rd_back;
  logic                skip, fm, bm, hit_f, hit_b, scan_end;
  logic [SeenBits-1:0] nth_ext, seen_f;
  logic [NodeBits-1:0] node_hi;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign ram_we   = accept && (in_req_i.kind == KIND_APPEND) &&
                    (total_q != CntBits'(MaxEdges));

  // Edge memory: front and back node of each edge.
  lget_ram #(
    .Width (EntryBits),
    .Depth (MaxEdges)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (total_q[IdxBits-1:0]),
    .wdata_i ({in_req_i.front_node, in_req_i.back_node}),
    .raddr_i (issue_q[IdxBits-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_front = ram_rdata[EntryBits-1:NodeBits];
  assign rd_back  = ram_rdata[NodeBits-1:0];

  // Match logic for the entry whose read data is back this cycle.
  assign skip    = req_q.ignore_enable && (pend_idx_q == req_q.ignore_edge);
  assign fm      = pend_q && !skip && (rd_front == req_q.query_node);
  assign bm      = pend_q && !skip && (rd_back == req_q.query_node);
  assign nth_ext = SeenBits'(req_q.nth);
  assign seen_f  = seen_q + SeenBits'(fm);
  assign hit_f   = (req_q.kind == KIND_FIND) && fm && (seen_q == nth_ext);
  assign hit_b   = (req_q.kind == KIND_FIND) && bm && (seen_f == nth_ext);
  assign scan_end = (issue_q == total_q);

  assign node_hi = (in_req_i.front_node > in_req_i.back_node) ?
                   in_req_i.front_node : in_req_i.back_node;

  // Sequencer, scan datapath and table statistics.
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    res_d      = res_q;
    total_d    = total_q;
    max_node_d = max_node_q;
    max_led_d  = max_led_q;
    issue_d    = issue_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    seen_d     = seen_q;
    conn_d     = conn_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d   = in_req_i;
          res_d   = '0;
          issue_d = '0;
          seen_d  = '0;
          conn_d  = '0;
          unique case (in_req_i.kind)
            KIND_CLEAR: begin
              total_d    = '0;
              max_node_d = '0;
              max_led_d  = '0;
              state_d    = S_DONE;
            end
            KIND_APPEND: begin
              if (total_q == CntBits'(MaxEdges)) begin
                res_d.full = 1'b1;
              end else begin
                total_d = total_q + 1'b1;
                if (total_q == '0) begin
                  max_node_d = node_hi;
                  max_led_d  = in_req_i.end_led;
                end else begin
                  if (node_hi > max_node_q) max_node_d = node_hi;
                  if (in_req_i.end_led > max_led_q) max_led_d = in_req_i.end_led;
                end
              end
              state_d = S_DONE;
            end
            KIND_COUNT, KIND_FIND: begin
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next read while the previous entry is checked.
        if (!scan_end) begin
          issue_d    = issue_q + 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = issue_q[IdxBits-1:0];
        end
        seen_d = seen_f + SeenBits'(bm);
        conn_d = conn_q + CntBits'(pend_q &&
                 ((rd_front == req_q.query_node) || (rd_back == req_q.query_node)));
        if (hit_f || hit_b) begin
          res_d.found = 1'b1;
          res_d.idx   = pend_idx_q;
          res_d.rev   = !hit_f;
          pend_d      = 1'b0;
          state_d     = S_DONE;
        end else if (scan_end) begin
          res_d.conn = (req_q.kind == KIND_COUNT) ? conn_d : '0;
          state_d    = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register load.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if ((state_q == S_DONE) && out_free) begin
      out_valid_d            = 1'b1;
      out_d.found            = res_q.found;
      out_d.edge_index       = res_q.idx;
      out_d.reversed         = res_q.rev;
      out_d.connection_count = res_q.conn;
      out_d.table_full       = res_q.full;
      out_d.node_count       = (total_q != '0) ? ({1'b0, max_node_q} + 1'b1) : '0;
      out_d.total_leds       = (total_q != '0) ? ({1'b0, max_led_q} + 1'b1) : '0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      max_node_q  <= '0;
      max_led_q   <= '0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
      max_node_q  <= max_node_d;
      max_led_q   <= max_led_d;
      pend_q      <= pend_d;
    end
  end

  // Payload and scan working registers.
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    out_q      <= out_d;
    issue_q    <= issue_d;
    pend_idx_q <= pend_idx_d;
    seen_q     <= seen_d;
    conn_q     <= conn_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // The edge count never passes the table size.
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntBits'(MaxEdges))
    else $error("edge count beyond table size");

  // The memory is written only while no scan is running.
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_IDLE))
    else $error("edge memory written during a scan");

  // A count or find request starts a scan in the next cycle.
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ((in_req_i.kind == KIND_COUNT) || (in_req_i.kind == KIND_FIND)))
    |=> (state_q == S_SCAN))
    else $error("scan did not start");

  // Only a find request can report a hit, and only on an entry in the table.
  a_found_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && res_q.found) |->
    ((req_q.kind == KIND_FIND) && (CntBits'(res_q.idx) < total_q)))
    else $error("hit reported outside a find");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// LED graph edge table testbench
// Drives clear, append, count and find requests into the edge table and
// checks every result field against a behavioral copy of the table. Both
// handshakes idle and stall at random.
// -----------------------------------------------------------------------------
module testbench;
  import lget_pkg::*;

  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned MaxReported = 10;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_req_i    = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_rsp_o;

  // Behavioral copy of the edge table.
  logic [NodeBits-1:0] tbl_front [MaxEdges];
  logic [NodeBits-1:0] tbl_back  [MaxEdges];
  logic [LedBits-1:0]  tbl_end   [MaxEdges];
  int unsigned         tbl_count    = 0;
  logic [NodeBits-1:0] tbl_max_node = '0;
  logic [LedBits-1:0]  tbl_max_led  = '0;

  // Results owed by the block, oldest first.
  out_t table_answers [$];

  int unsigned fail_count   = 0;
  int unsigned rsp_checked  = 0;
  int unsigned idle_cycles  = 0;
  int unsigned stall_left   = 0;
  bit          no_idle      = 1'b0;
  int unsigned n_clear      = 0;
  int unsigned n_append     = 0;
  int unsigned n_dropped    = 0;
  int unsigned n_count      = 0;
  int unsigned n_find       = 0;
  int unsigned n_find_hit   = 0;

  led_graph_edge_table u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Applies one request to the table copy and returns the result it must give.
  function automatic out_t edge_table_answer(input in_t req);
    out_t        rsp;
    int unsigned seen;
    int unsigned i;
    bit          hit;
    rsp  = '0;
    seen = 0;
    hit  = 1'b0;
    case (req.kind)
      KIND_CLEAR: begin
        n_clear++;
        tbl_count    = 0;
        tbl_max_node = '0;
        tbl_max_led  = '0;
      end
      KIND_APPEND: begin
        n_append++;
        if (tbl_count >= MaxEdges) begin
          rsp.table_full = 1'b1;
          n_dropped++;
        end else begin
          tbl_front[tbl_count] = req.front_node;
          tbl_back[tbl_count]  = req.back_node;
          tbl_end[tbl_count]   = req.end_led;
          // The first edge after a clear restarts both maxima.
          if (tbl_count == 0) begin
            tbl_max_node = (req.front_node > req.back_node) ? req.front_node : req.back_node;
            tbl_max_led  = req.end_led;
          end else begin
            if (req.front_node > tbl_max_node) tbl_max_node = req.front_node;
            if (req.back_node > tbl_max_node) tbl_max_node = req.back_node;
            if (req.end_led > tbl_max_led) tbl_max_led = req.end_led;
          end
          tbl_count++;
        end
      end
      KIND_COUNT: begin
        n_count++;
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_front[i] == req.query_node || tbl_back[i] == req.query_node) begin
            rsp.connection_count = rsp.connection_count + 1'b1;
          end
        end
      end
      default: begin
        n_find++;
        // A self-loop on the query node counts twice: front first, then back.
        for (i = 0; i < tbl_count && !hit; i++) begin
          if (!(req.ignore_enable && i == req.ignore_edge)) begin
            if (tbl_front[i] == req.query_node) begin
              if (seen == req.nth) begin
                hit            = 1'b1;
                rsp.found      = 1'b1;
                rsp.edge_index = IdxBits'(i);
                rsp.reversed   = 1'b0;
              end
              seen++;
            end
            if (!hit && tbl_back[i] == req.query_node) begin
              if (seen == req.nth) begin
                hit            = 1'b1;
                rsp.found      = 1'b1;
                rsp.edge_index = IdxBits'(i);
                rsp.reversed   = 1'b1;
              end
              seen++;
            end
          end
        end
        if (hit) n_find_hit++;
      end
    endcase
    rsp.node_count = (tbl_count != 0) ? ({1'b0, tbl_max_node} + 1'b1) : '0;
    rsp.total_leds = (tbl_count != 0) ? ({1'b0, tbl_max_led} + 1'b1) : '0;
    return rsp;
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxReported) $display("%0t ns: %s", $time, msg);
  endtask

  // Compares one accepted result with the oldest owed result.
  task automatic check_result(input out_t got);
    out_t want;
    if (table_answers.size() == 0) begin
      report_failure($sformatf("result %h arrived with no request pending", got));
      return;
    end
    want = table_answers.pop_front();
    rsp_checked++;
    if (got.found !== want.found)
      report_failure($sformatf("result %0d found: expected %0h actual %0h",
                               rsp_checked, want.found, got.found));
    if (got.edge_index !== want.edge_index)
      report_failure($sformatf("result %0d edge_index: expected %0h actual %0h",
                               rsp_checked, want.edge_index, got.edge_index));
    if (got.reversed !== want.reversed)
      report_failure($sformatf("result %0d reversed: expected %0h actual %0h",
                               rsp_checked, want.reversed, got.reversed));
    if (got.connection_count !== want.connection_count)
      report_failure($sformatf("result %0d connection_count: expected %0h actual %0h",
                               rsp_checked, want.connection_count, got.connection_count));
    if (got.node_count !== want.node_count)
      report_failure($sformatf("result %0d node_count: expected %0h actual %0h",
                               rsp_checked, want.node_count, got.node_count));
    if (got.total_leds !== want.total_leds)
      report_failure($sformatf("result %0d total_leds: expected %0h actual %0h",
                               rsp_checked, want.total_leds, got.total_leds));
    if (got.table_full !== want.table_full)
      report_failure($sformatf("result %0d table_full: expected %0h actual %0h",
                               rsp_checked, want.table_full, got.table_full));
  endtask

  // Result side: check each accepted result, then stall for a random stretch.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (out_valid_o && !out_stall_i) begin
        check_result(out_rsp_o);
        stall_left = no_idle ? 0 : $urandom_range(0, 11);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // Sends one request after a random gap and records the result it owes.
  task automatic send_request(input in_t req);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    table_answers.push_back(edge_table_answer(req));
  endtask

  // A request of the given kind with every field random.
  function automatic in_t random_request(input kind_e kind);
    logic [63:0] raw;
    in_t         req;
    raw      = {$urandom, $urandom};
    req      = raw[$bits(in_t)-1:0];
    req.kind = kind;
    return req;
  endfunction

  task automatic send_clear();
    send_request(random_request(KIND_CLEAR));
  endtask

  task automatic send_append(input logic [NodeBits-1:0] front, input logic [NodeBits-1:0] back,
                             input logic [LedBits-1:0] end_led);
    in_t req;
    req            = random_request(KIND_APPEND);
    req.front_node = front;
    req.back_node  = back;
    req.end_led    = end_led;
    send_request(req);
  endtask

  task automatic send_count(input logic [NodeBits-1:0] node);
    in_t req;
    req            = random_request(KIND_COUNT);
    req.query_node = node;
    send_request(req);
  endtask

  task automatic send_find(input logic [NodeBits-1:0] node, input logic [NthBits-1:0] nth,
                           input logic skip_en, input logic [IdxBits-1:0] skip_edge);
    in_t req;
    req               = random_request(KIND_FIND);
    req.query_node    = node;
    req.nth           = nth;
    req.ignore_enable = skip_en;
    req.ignore_edge   = skip_edge;
    send_request(req);
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (table_answers.size() != 0);
  endtask

  // Extremes of the fields, self-loops, skipped edges and empty-table queries.
  task automatic test_directed();
    send_clear();
    send_count(8'd0);
    send_find(8'd0, 7'd0, 1'b0, 6'd0);
    send_append(8'd0, 8'd255, 16'hffff);
    send_append(8'd255, 8'd0, 16'h0000);
    send_append(8'd7, 8'd7, 16'd100);
    send_count(8'd7);
    send_count(8'd255);
    send_find(8'd7, 7'd0, 1'b0, 6'd0);
    send_find(8'd7, 7'd1, 1'b0, 6'd0);
    send_find(8'd7, 7'd2, 1'b0, 6'd0);
    send_find(8'd255, 7'd0, 1'b0, 6'd0);
    send_find(8'd255, 7'd1, 1'b0, 6'd0);
    send_find(8'd255, 7'd0, 1'b1, 6'd0);
    send_find(8'd255, 7'd0, 1'b1, 6'd63);
    send_find(8'd255, 7'd127, 1'b0, 6'd63);
    send_find(8'd0, 7'd1, 1'b0, 6'd0);
    send_append(8'd3, 8'd1, 16'd5);
    send_clear();
    send_count(8'd255);
    send_append(8'd0, 8'd0, 16'd0);
    send_find(8'd0, 7'd1, 1'b0, 6'd0);
    send_clear();
  endtask

  // Fills the table to its limit, overflows it and searches the full table.
  task automatic test_full_table();
    logic [NodeBits-1:0] hub;
    int unsigned         i;
    hub = NodeBits'($urandom);
    wait_for_drain();
    send_clear();
    for (i = 0; i < MaxEdges; i++) begin
      send_append(($urandom_range(0, 2) == 0) ? hub : NodeBits'($urandom),
                  ($urandom_range(0, 2) == 0) ? hub : NodeBits'($urandom),
                  LedBits'($urandom));
    end
    send_append(hub, hub, 16'hffff);
    send_append(NodeBits'($urandom), NodeBits'($urandom), LedBits'($urandom));
    send_count(hub);
    send_find(hub, 7'd0, 1'b0, 6'd0);
    send_find(hub, NthBits'($urandom_range(0, 40)), 1'b1, IdxBits'($urandom));
    send_find(hub, 7'd127, 1'b1, 6'd63);
    send_find(tbl_back[MaxEdges-1], 7'd0, 1'b1, IdxBits'($urandom_range(0, MaxEdges - 2)));
    send_clear();
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_back_to_back();
    logic [NodeBits-1:0] hub;
    int unsigned         i;
    hub     = NodeBits'($urandom);
    no_idle = 1'b1;
    send_clear();
    for (i = 0; i < 20; i++) begin
      send_append(($urandom_range(0, 1) == 0) ? hub : NodeBits'($urandom),
                  NodeBits'($urandom), LedBits'($urandom));
    end
    for (i = 0; i < 40; i++) begin
      if (i % 2 == 0) send_count(hub);
      else send_find(hub, NthBits'($urandom_range(0, 8)), ($urandom_range(0, 1) != 0),
                     IdxBits'($urandom_range(0, 20)));
    end
    no_idle = 1'b0;
  endtask

  // Sessions of appends around a few shared nodes followed by queries on them,
  // with fully random requests mixed in as noise.
  task automatic test_random_sessions(input int unsigned item_target);
    logic [NodeBits-1:0] hub [4];
    int unsigned         sent;
    int unsigned         fill;
    int unsigned         queries;
    int unsigned         i;
    in_t                 req;
    sent = 0;
    while (sent < item_target) begin
      for (i = 0; i < 4; i++) hub[i] = NodeBits'($urandom);
      // Sometimes keep the old table so that it grows toward full.
      if ($urandom_range(0, 3) != 0) begin
        send_clear();
        sent++;
      end
      fill = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 10);
      for (i = 0; i < fill; i++) begin
        send_append(($urandom_range(0, 4) != 0) ? hub[$urandom_range(0, 3)]
                                                 : NodeBits'($urandom),
                    ($urandom_range(0, 4) != 0) ? hub[$urandom_range(0, 3)]
                                                 : NodeBits'($urandom),
                    LedBits'($urandom));
        sent++;
      end
      queries = $urandom_range(4, 16);
      for (i = 0; i < queries; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(random_request(kind_e'($urandom_range(0, 3))));
        end else begin
          req            = random_request(($urandom_range(0, 2) == 0) ? KIND_COUNT : KIND_FIND);
          req.query_node = ($urandom_range(0, 6) != 0) ? hub[$urandom_range(0, 3)]
                                                       : NodeBits'($urandom);
          if ($urandom_range(0, 3) != 0) req.nth = NthBits'($urandom_range(0, 5));
          if ($urandom_range(0, 1) == 0)
            req.ignore_edge = IdxBits'($urandom_range(0, (tbl_count < MaxEdges) ?
                                                         tbl_count : MaxEdges - 1));
          send_request(req);
        end
        sent++;
      end
      if ($urandom_range(0, 15) == 0) wait_for_drain();
    end
  endtask

  // Ends the run when nothing has moved for too long.
  initial begin
    wait (rst_ni);
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("Timeout: no request or result moved for %0d cycles", IdleLimit);
    $display("led_graph_edge_table verification failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_table();
    test_back_to_back();
    wait_for_drain();
    test_random_sessions(790);

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (table_answers.size() != 0) begin
      report_failure($sformatf("%0d results never arrived", table_answers.size()));
    end

    $display("Checked %0d results: %0d clears, %0d appends (%0d dropped when full),",
             rsp_checked, n_clear, n_append, n_dropped);
    $display("%0d counts and %0d finds (%0d located an edge); %0d failures.",
             n_count, n_find, n_find_hit, fail_count);
    if (fail_count == 0) begin
      $display("led_graph_edge_table verification clean");
    end else begin
      $display("led_graph_edge_table verification failed");
    end
    $finish;
  end

endmodule
